// ===== rtl/mubs_pkg.sv =====
// shared constants for the mesh bounding-box unitizer
`default_nettype none

package mubs_pkg;

    // default coordinate width in bits, two's complement
    localparam int DEF_COORD_WIDTH = 32;

    // default count of fractional bits in a coordinate
    localparam int DEF_FRAC_BITS = 16;

    // boxes held between the bounds tracker and the scale unit
    localparam int QUEUE_DEPTH = 2;

    // number of coordinate-wide words in one packed box: lo/hi for x, y, z
    localparam int BOX_WORDS = 6;

endpackage

`default_nettype wire

// ===== rtl/mubs_front.sv =====
// bounds tracker: running per-axis min and max, hands a closed box on the last vertex
`default_nettype none

module mubs_front #(
    parameter int COORD_WIDTH = mubs_pkg::DEF_COORD_WIDTH
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [COORD_WIDTH-1:0]                 coord_x,
    input  logic signed [COORD_WIDTH-1:0]                 coord_y,
    input  logic signed [COORD_WIDTH-1:0]                 coord_z,
    input  logic                                          last_vertex,
    output logic                                          box_valid,
    input  logic                                          box_ready,
    output logic [mubs_pkg::BOX_WORDS*COORD_WIDTH-1:0]    box_data
);

    logic signed [COORD_WIDTH-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic signed [COORD_WIDTH-1:0] lo_z_reg, hi_z_reg;
    logic signed [COORD_WIDTH-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;
    logic signed [COORD_WIDTH-1:0] lo_z_next, hi_z_next;
    logic                          started_reg;
    logic                          accept;

    // a box can only be closed when the queue has room
    assign in_ready = box_ready;
    assign accept   = in_valid && in_ready;

    // first vertex of a set loads the box, later ones widen it
    always_comb
    begin
        lo_x_next = (!started_reg || coord_x < lo_x_reg) ? coord_x : lo_x_reg;
        hi_x_next = (!started_reg || coord_x > hi_x_reg) ? coord_x : hi_x_reg;
        lo_y_next = (!started_reg || coord_y < lo_y_reg) ? coord_y : lo_y_reg;
        hi_y_next = (!started_reg || coord_y > hi_y_reg) ? coord_y : hi_y_reg;
        lo_z_next = (!started_reg || coord_z < lo_z_reg) ? coord_z : lo_z_reg;
        hi_z_next = (!started_reg || coord_z > hi_z_reg) ? coord_z : hi_z_reg;
    end

    assign box_valid = accept && last_vertex;
    assign box_data  = {lo_x_next, hi_x_next, lo_y_next, hi_y_next, lo_z_next, hi_z_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else if (accept)
        begin
            started_reg <= !last_vertex;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_x_reg <= lo_x_next;
            hi_x_reg <= hi_x_next;
            lo_y_reg <= lo_y_next;
            hi_y_reg <= hi_y_next;
            lo_z_reg <= lo_z_next;
            hi_z_reg <= hi_z_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mubs_queue.sv =====
// small register queue carrying closed boxes from the tracker to the scale unit
`default_nettype none

module mubs_queue #(
    parameter int WIDTH = mubs_pkg::BOX_WORDS * mubs_pkg::DEF_COORD_WIDTH,
    parameter int DEPTH = mubs_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mubs_back.sv =====
// scale unit: centre, extents, largest extent and a bit-serial reciprocal divide
`default_nettype none

module mubs_back #(
    parameter int COORD_WIDTH = mubs_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mubs_pkg::DEF_FRAC_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          box_valid,
    output logic                                          box_ready,
    input  logic [mubs_pkg::BOX_WORDS*COORD_WIDTH-1:0]    box_data,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [COORD_WIDTH-1:0]                        scale_factor,
    output logic signed [COORD_WIDTH-1:0]                 center_x,
    output logic signed [COORD_WIDTH-1:0]                 center_y,
    output logic signed [COORD_WIDTH-1:0]                 center_z,
    output logic                                          degenerate
);

    localparam int W    = COORD_WIDTH;
    // dividend is 2^(2*FRAC_BITS+1), this many bits wide
    localparam int NW   = 2 * FRAC_BITS + 2;
    // quotient register keeps at least one bit above the field for overflow
    localparam int QW   = (NW > W) ? NW : W + 1;
    localparam int CNTW = $clog2(NW + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_MAX, ST_DIV, ST_DONE} state_t;

    state_t          state_reg;
    logic [W:0]      ext_x_reg, ext_y_reg, ext_z_reg, ext_max_reg;
    logic [W-1:0]    cen_x_reg, cen_y_reg, cen_z_reg;
    logic [W:0]      rem_reg;
    logic [QW-1:0]   quot_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            zero_reg;

    logic [W-1:0]    lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic [W:0]      ext_x, ext_y, ext_z, ext_xy, ext_max;
    logic [W-1:0]    cen_x, cen_y, cen_z;
    logic [W+1:0]    rem_sh, rem_sub;
    logic            qbit, ovf;
    logic            load_out;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // (lo + hi) / 2 rounded toward zero
    function automatic logic [W-1:0] mid(input logic [W-1:0] lo, input logic [W-1:0] hi);
        logic [W:0] sum;
        logic [W:0] adj;
        sum = {lo[W-1], lo} + {hi[W-1], hi};
        adj = sum + {{W{1'b0}}, sum[W] & sum[0]};
        mid = adj[W:1];
    endfunction

    assign lo_x = box_data[6*W-1 -: W];
    assign hi_x = box_data[5*W-1 -: W];
    assign lo_y = box_data[4*W-1 -: W];
    assign hi_y = box_data[3*W-1 -: W];
    assign lo_z = box_data[2*W-1 -: W];
    assign hi_z = box_data[W-1 -: W];

    always_comb
    begin
        ext_x   = {1'b0, mag(hi_x)} + {1'b0, mag(lo_x)};
        ext_y   = {1'b0, mag(hi_y)} + {1'b0, mag(lo_y)};
        ext_z   = {1'b0, mag(hi_z)} + {1'b0, mag(lo_z)};
        cen_x   = mid(lo_x, hi_x);
        cen_y   = mid(lo_y, hi_y);
        cen_z   = mid(lo_z, hi_z);
        ext_xy  = (ext_y_reg > ext_x_reg) ? ext_y_reg : ext_x_reg;
        ext_max = (ext_z_reg > ext_xy) ? ext_z_reg : ext_xy;
    end

    // restoring divide step; the dividend's only set bit enters on the first step
    always_comb
    begin
        rem_sh  = {rem_reg, (cnt_reg == CNTW'(NW))};
        rem_sub = rem_sh - {1'b0, ext_max_reg};
        qbit    = (rem_sh >= {1'b0, ext_max_reg});
        ovf     = |quot_reg[QW-1:W];
    end

    assign box_ready = (state_reg == ST_IDLE);
    // result register takes a new beat when empty or being drained
    assign load_out  = (state_reg == ST_DONE) && (!out_valid || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_valid    <= 1'b0;
            ext_x_reg    <= '0;
            ext_y_reg    <= '0;
            ext_z_reg    <= '0;
            ext_max_reg  <= '0;
            cen_x_reg    <= '0;
            cen_y_reg    <= '0;
            cen_z_reg    <= '0;
            rem_reg      <= '0;
            quot_reg     <= '0;
            cnt_reg      <= '0;
            zero_reg     <= 1'b0;
            scale_factor <= '0;
            center_x     <= '0;
            center_y     <= '0;
            center_z     <= '0;
            degenerate   <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && !load_out)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (box_valid)
                    begin
                        ext_x_reg <= ext_x;
                        ext_y_reg <= ext_y;
                        ext_z_reg <= ext_z;
                        cen_x_reg <= cen_x;
                        cen_y_reg <= cen_y;
                        cen_z_reg <= cen_z;
                        state_reg <= ST_MAX;
                    end
                end
                ST_MAX:
                begin
                    ext_max_reg <= ext_max;
                    rem_reg     <= '0;
                    quot_reg    <= '0;
                    cnt_reg     <= CNTW'(NW);
                    zero_reg    <= (ext_max == '0);
                    state_reg   <= (ext_max == '0) ? ST_DONE : ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= qbit ? rem_sub[W:0] : rem_sh[W:0];
                    quot_reg <= {quot_reg[QW-2:0], qbit};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        scale_factor <= (zero_reg || ovf) ? {W{1'b1}} : quot_reg[W-1:0];
                        degenerate   <= zero_reg || ovf;
                        center_x     <= cen_x_reg;
                        center_y     <= cen_y_reg;
                        center_z     <= cen_z_reg;
                        out_valid    <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mesh_unitize_bounds_scale.sv =====
// top level of the mesh bounding-box unitizer: tracker, box queue and scale unit
//
// input channel (in_valid/in_ready): one vertex per beat, x/y/z in signed
// fixed point with FRAC_BITS fraction bits; last_vertex closes the set.
// the first vertex after reset or after a closing vertex opens a new set.
// output channel (out_valid/out_ready): one beat per closed set with the box
// centre (mid of min and max, rounded toward zero) and the scale
// 2 / largest extent, where an extent is |max| + |min| of its axis.
// degenerate marks a zero extent or a scale too large for the field; the
// scale then reads all ones.
// throughput: the tracker takes one vertex per cycle while the queue has room;
// each set passes through the scale unit as load, largest-extent pick, one
// quotient bit per cycle in the restoring divider, then result load; a
// zero-extent set skips the divider. up to QUEUE_DEPTH closed boxes wait
// between tracker and scale unit, so short sets only stall input once the
// queue and the divider are both busy.
// a stalled receiver holds the result register; the scale unit waits in its
// result state and the queue, then the input, back up behind it.
// reset clears the set-open flag, the queue and the output valid.
`default_nettype none

module mesh_unitize_bounds_scale #(
    parameter int COORD_WIDTH = mubs_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = mubs_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic                          last_vertex,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_WIDTH-1:0]        scale_factor,
    output logic signed [COORD_WIDTH-1:0] center_x,
    output logic signed [COORD_WIDTH-1:0] center_y,
    output logic signed [COORD_WIDTH-1:0] center_z,
    output logic                          degenerate
);

    // packed box: lo_x, hi_x, lo_y, hi_y, lo_z, hi_z from the top down
    localparam int BOX_W = mubs_pkg::BOX_WORDS * COORD_WIDTH;

    logic             push_valid, push_ready;
    logic [BOX_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [BOX_W-1:0] pop_data;

    // running min/max per axis, emits the closed box with the last vertex
    mubs_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .last_vertex (last_vertex),
        .box_valid   (push_valid),
        .box_ready   (push_ready),
        .box_data    (push_data)
    );

    // decouples vertex intake from the slow divide
    mubs_queue #(
        .WIDTH (BOX_W),
        .DEPTH (mubs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // centre, extents and the bit-serial reciprocal
    mubs_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .box_valid    (pop_valid),
        .box_ready    (pop_ready),
        .box_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scale_factor (scale_factor),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .degenerate   (degenerate)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_mesh_unitize_bounds_scale.sv =====
// self-checking testbench for the mesh bounding-box unitizer
`default_nettype none

module tb_mesh_unitize_bounds_scale;

    localparam int CW = mubs_pkg::DEF_COORD_WIDTH;
    localparam int FB = mubs_pkg::DEF_FRAC_BITS;

    // clock period and run bounds
    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    // covers one set through the divider, with a little slack on top
    localparam int SETTLE_CYCLES = 2 * FB + 13;
    // random vertices per random phase, about 1550 items over the whole run
    localparam int PHASE_ITEMS = 380;

    // numerator of the unitizing scale: 2.0 times one in raw fixed point
    localparam longint unsigned SCALE_NUM  = 64'd1 << (2 * FB + 1);
    localparam longint unsigned COORD_MASK = (64'd1 << CW) - 64'd1;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE_FIXED = 1 <<< FB;

    // how the coordinates of one random set are spread
    typedef enum int
    {
        SPREAD_FULL,
        SPREAD_NEAR,
        SPREAD_TINY,
        SPREAD_MIXED
    } coord_spread_t;

    // one expected output beat
    typedef struct
    {
        logic [CW-1:0] scale;
        logic [CW-1:0] mid_x;
        logic [CW-1:0] mid_y;
        logic [CW-1:0] mid_z;
        logic          degen;
    } box_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic signed [CW-1:0] coord_z;
    logic                 last_vertex;
    logic                 out_valid;
    logic                 out_ready;
    logic [CW-1:0]        scale_factor;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic                 degenerate;

    // predicted box of the open set, one entry per axis (x, y, z)
    longint box_lo [3];
    longint box_hi [3];
    bit     set_open;

    // boxes closed at the input whose output beat has not arrived yet
    box_result_t boxes_due [$];

    int failures;
    int cycle_count;
    // chance in percent that the sender idles or the receiver stalls in a cycle
    int idle_pct;
    int stall_pct;

    mesh_unitize_bounds_scale #(
        .COORD_WIDTH (CW),
        .FRAC_BITS   (FB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .last_vertex  (last_vertex),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scale_factor (scale_factor),
        .center_x     (center_x),
        .center_y     (center_y),
        .center_z     (center_z),
        .degenerate   (degenerate)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t watchdog expired with %0d boxes outstanding", $time,
                     boxes_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // mid of the box, the halving truncates toward zero like the hardware
    function automatic logic [CW-1:0] box_mid(input longint lo, input longint hi);
        longint sum;
        sum = lo + hi;
        return CW'(sum / 2);
    endfunction

    // update the running box with one accepted vertex; on the closing vertex
    // work out centre and scale and queue them for the checker
    task automatic fold_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z, input logic closes);
        longint            v [3];
        longint unsigned   extent;
        longint unsigned   widest;
        longint unsigned   quot;
        box_result_t       r;
        int                a;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        for (a = 0; a < 3; a++)
        begin
            // first vertex of a set loads the bounds instead of widening them
            if (!set_open)
            begin
                box_lo[a] = v[a];
                box_hi[a] = v[a];
            end
            else
            begin
                if (v[a] > box_hi[a])
                    box_hi[a] = v[a];
                if (v[a] < box_lo[a])
                    box_lo[a] = v[a];
            end
        end
        set_open = 1'b1;
        if (closes)
        begin
            // extent per axis is |max| + |min|, not max - min
            widest = 0;
            for (a = 0; a < 3; a++)
            begin
                extent = magnitude(box_hi[a]) + magnitude(box_lo[a]);
                if (extent > widest)
                    widest = extent;
            end
            r.degen = 1'b0;
            if (widest == 0)
            begin
                r.scale = '1;
                r.degen = 1'b1;
            end
            else
            begin
                quot = SCALE_NUM / widest;
                if (quot > COORD_MASK)
                begin
                    r.scale = '1;
                    r.degen = 1'b1;
                end
                else
                    r.scale = quot[CW-1:0];
            end
            r.mid_x = box_mid(box_lo[0], box_hi[0]);
            r.mid_y = box_mid(box_lo[1], box_hi[1]);
            r.mid_z = box_mid(box_lo[2], box_hi[2]);
            boxes_due.push_back(r);
            set_open = 1'b0;
        end
    endtask

    task automatic check_field(input string label, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t mismatch on %s: expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // compare every accepted output beat with the oldest closed box
    always @(posedge clk)
    begin : result_check
        box_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (boxes_due.size() == 0)
            begin
                failures++;
                $display("%0t unexpected beat: expected none, actual scale %h centre %h %h %h",
                         $time, scale_factor, center_x, center_y, center_z);
            end
            else
            begin
                want = boxes_due.pop_front();
                check_field("scale_factor", want.scale, scale_factor);
                check_field("center_x", want.mid_x, center_x);
                check_field("center_y", want.mid_y, center_y);
                check_field("center_z", want.mid_z, center_z);
                check_field("degenerate", CW'(want.degen), CW'(degenerate));
            end
        end
    end

    // drive one vertex at a falling edge, hold it until the block takes it,
    // then fold it into the predicted box; valid stays high between beats
    // unless the sender decides to idle
    task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z, input logic closes);
        @(negedge clk);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        last_vertex <= closes;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        fold_vertex(x, y, z, closes);
    endtask

    // drop valid and hold off until every closed box has come out
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (boxes_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] random_coord(input coord_spread_t spread);
        coord_spread_t s;
        int            offset;
        // now and then an extreme value whatever the spread
        if ($urandom_range(0, 15) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return COORD_MAX;
                1:       return COORD_MIN;
                2:       return '0;
                3:       return '1;
                default: return 1;
            endcase
        end
        s = spread;
        if (s == SPREAD_MIXED)
            s = coord_spread_t'($urandom_range(0, 2));
        case (s)
            SPREAD_FULL:
                return CW'({$urandom, $urandom});
            SPREAD_NEAR:
            begin
                offset = int'($urandom_range(0, 2097152)) - 1048576;
                return CW'(offset);
            end
            default:
            begin
                // a few raw units: zero extents and overflowing scales
                offset = int'($urandom_range(0, 6)) - 3;
                return CW'(offset);
            end
        endcase
    endfunction

    // closed sets of random length until about item_count vertices are sent
    task automatic send_random_sets(input int item_count);
        int            sent;
        int            len;
        int            i;
        coord_spread_t spread;
        sent = 0;
        while (sent < item_count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                6, 7, 8:          len = $urandom_range(5, 16);
                default:          len = $urandom_range(17, 60);
            endcase
            spread = coord_spread_t'($urandom_range(0, 3));
            for (i = 0; i < len; i++)
                send_vertex(random_coord(spread), random_coord(spread), random_coord(spread),
                            i == len - 1);
            sent += len;
        end
    endtask

    // corners of the arithmetic: zero extent, overflow, smallest fitting
    // extent, unit scale, full-range coordinates, rounding toward zero and
    // re-opening of the box after a closing vertex
    task automatic test_directed_corners();
        idle_pct  = 0;
        stall_pct = 0;
        // zero extent saturates the scale
        send_vertex(0, 0, 0, 1'b1);
        // extent of two raw units: quotient too large for the field
        send_vertex(1, -1, 0, 1'b1);
        // extent of three units, the smallest that fits
        send_vertex(1, 0, 0, 1'b0);
        send_vertex(-2, 0, 0, 1'b1);
        // extent 2.0 gives a scale of exactly one
        send_vertex(ONE_FIXED, -ONE_FIXED, ONE_FIXED >>> 1, 1'b1);
        // single vertex at the field limits: centre is the vertex itself
        send_vertex(COORD_MAX, COORD_MIN, -1, 1'b1);
        // widest box: centre of -0.5 raw rounds to zero
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        // odd sums on both sides of zero
        send_vertex(-3, -5, 7, 1'b0);
        send_vertex(0, 0, 0, 1'b1);
        // a fresh set must not inherit the wide bounds above
        send_vertex(5, 6, 7, 1'b0);
        send_vertex(9, 2, 8, 1'b0);
        send_vertex(4, 10, -1, 1'b1);
        // alternating bit patterns
        send_vertex(CW'(32'hAAAA_AAAA), CW'(32'h5555_5555), CW'(32'hFFFF_0000), 1'b1);
        // box away from the origin: extent |max| + |min|, not max - min
        send_vertex(2 * ONE_FIXED, 2 * ONE_FIXED, 2 * ONE_FIXED, 1'b0);
        send_vertex(3 * ONE_FIXED, 3 * ONE_FIXED, 3 * ONE_FIXED, 1'b1);
    endtask

    task automatic test_random_no_idle();
        idle_pct  = 0;
        stall_pct = 0;
        send_random_sets(PHASE_ITEMS);
    endtask

    // sender stops mid-run until the block has nothing left, then resumes
    task automatic test_drain_pause();
        idle_pct  = 0;
        stall_pct = 0;
        send_random_sets(12);
        wait_until_drained();
        send_random_sets(12);
    endtask

    task automatic test_random_sender_idle();
        idle_pct  = 61;
        stall_pct = 0;
        send_random_sets(PHASE_ITEMS);
    endtask

    task automatic test_random_receiver_stall();
        idle_pct  = 0;
        stall_pct = 61;
        send_random_sets(PHASE_ITEMS);
    endtask

    task automatic test_random_both_idle();
        idle_pct  = 37;
        stall_pct = 37;
        send_random_sets(PHASE_ITEMS);
    endtask

    initial
    begin
        // every input known from time zero, reset released at a falling edge
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        coord_x     = '0;
        coord_y     = '0;
        coord_z     = '0;
        last_vertex = 1'b0;
        out_ready   = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        failures    = 0;
        cycle_count = 0;
        set_open    = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = 0;
            box_hi[a] = 0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_no_idle();
        test_drain_pause();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        // let the divider finish and catch any stray beat afterwards
        wait_until_drained();
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && boxes_due.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            if (boxes_due.size() != 0)
                $display("%0t %0d boxes never came out", $time, boxes_due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
